// File: sv/pfdq_pkg.sv
// ----------------------------------------------------------------------------
// pfdq_pkg
// shared sizes, codes and command/flag bundles for the pointing frame
// deframer and encounter queue
// ----------------------------------------------------------------------------
package pfdq_pkg;

  localparam int ENTRY_DEPTH     = 512;
  localparam int ENCOUNTER_DEPTH = 8;
  localparam int TIME_DIGITS     = 14;

  localparam int ENTRY_PTR_W = $clog2(ENTRY_DEPTH);
  localparam int USED_W      = $clog2(ENTRY_DEPTH + 1);
  localparam int ENC_PTR_W   = $clog2(ENCOUNTER_DEPTH);
  localparam int QUEUED_W    = $clog2(ENCOUNTER_DEPTH + 1);
  localparam int POS_W       = $clog2(TIME_DIGITS + 1);
  localparam int PAD_LEN     = (4 - ((2 + TIME_DIGITS) % 4)) % 4;

  localparam logic [7:0] MARK_HI   = 8'hC2;
  localparam logic [7:0] MARK_LO   = 8'hAA;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_COMMIT    = 3'd1,
    ST_BAD_DIGIT = 3'd2,
    ST_FULL      = 3'd3,
    ST_EXEC      = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef struct packed {
    logic    shift;
    logic    clear_partial;
    logic    write_entry;
    logic    discard;
    logic    commit;
    logic    tick;
    logic    res_load;
    logic    out_load;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic partial_is_hi;
    logic store_full;
    logic enc_full;
  } flags_t;

endpackage

// File: sv/pfdq_ctrl.sv
// ----------------------------------------------------------------------------
// pfdq_ctrl
// handshake sequencer and frame parser state machine, drives datapath commands
// ----------------------------------------------------------------------------
module pfdq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pfdq_pkg::flags_t      flags,
  output pfdq_pkg::cmd_t        cmd
);

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_TICK,
    SEQ_HOLD
  } seq_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SAW_HI,
    PH_SAW_MK,
    PH_SAW_MK_HI,
    PH_DIGITS,
    PH_PAD,
    PH_WORD
  } phase_t;

  localparam logic [pfdq_pkg::POS_W-1:0] POS_ONE   = pfdq_pkg::POS_W'(1);
  localparam logic [pfdq_pkg::POS_W-1:0] POS_THREE = pfdq_pkg::POS_W'(3);
  localparam logic [pfdq_pkg::POS_W-1:0] POS_DIGS  = pfdq_pkg::POS_W'(pfdq_pkg::TIME_DIGITS);
  localparam logic [pfdq_pkg::POS_W-1:0] POS_PAD   = pfdq_pkg::POS_W'(pfdq_pkg::PAD_LEN);

  seq_t                        seq, seq_next;
  phase_t                      phase, phase_next;
  logic [pfdq_pkg::POS_W-1:0]  pos, pos_next;
  logic                        accept;
  logic                        is_digit;
  logic                        open_frame;
  logic [pfdq_pkg::POS_W-1:0]  dig_inc;
  logic [pfdq_pkg::POS_W-1:0]  pad_dec;
  logic                        out_free;
  pfdq_pkg::cmd_t              pcmd;

  assign in_ready   = (seq == SEQ_IDLE);
  assign accept     = in_valid && in_ready;
  assign is_digit   = (rx_byte >= pfdq_pkg::CHAR_ZERO) && (rx_byte <= pfdq_pkg::CHAR_NINE);
  assign open_frame = (pos != '0);
  assign dig_inc    = ((phase == PH_SAW_MK) ? '0 : pos) + POS_ONE;
  assign pad_dec    = (pos != '0) ? pos - POS_ONE : pos;
  assign out_free   = !out_valid || out_ready;

  // parser decision for one byte
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    pcmd       = '0;
    pcmd.code  = pfdq_pkg::ST_TAKEN;
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == pfdq_pkg::MARK_HI) begin
          phase_next = PH_SAW_HI;
          pos_next   = '0;
        end
      end
      PH_SAW_HI: begin
        if (rx_byte == pfdq_pkg::MARK_LO) begin
          phase_next = PH_SAW_MK;
        end else if (open_frame) begin
          pcmd.discard       = 1'b1;
          pcmd.clear_partial = 1'b1;
          pcmd.code          = pfdq_pkg::ST_BAD_DIGIT;
          phase_next         = PH_HUNT;
          pos_next           = '0;
        end else if (rx_byte != pfdq_pkg::MARK_HI) begin
          phase_next = PH_HUNT;
        end
      end
      PH_SAW_MK_HI: begin
        if (rx_byte == pfdq_pkg::MARK_LO && open_frame) begin
          pcmd.clear_partial = 1'b1;
          phase_next         = PH_HUNT;
          pos_next           = '0;
          if (flags.enc_full) begin
            pcmd.discard = 1'b1;
            pcmd.code    = pfdq_pkg::ST_FULL;
          end else begin
            pcmd.commit = 1'b1;
            pcmd.code   = pfdq_pkg::ST_COMMIT;
          end
        end else if (rx_byte == pfdq_pkg::MARK_LO) begin
          phase_next = PH_HUNT;
          pos_next   = '0;
        end else begin
          pcmd.discard       = 1'b1;
          pcmd.clear_partial = 1'b1;
          pcmd.code          = pfdq_pkg::ST_BAD_DIGIT;
          phase_next         = PH_HUNT;
          pos_next           = '0;
        end
      end
      PH_SAW_MK, PH_DIGITS: begin
        if (phase == PH_SAW_MK && rx_byte == pfdq_pkg::MARK_HI) begin
          phase_next = PH_SAW_MK_HI;
        end else if (phase == PH_DIGITS && pos == '0 && rx_byte == pfdq_pkg::MARK_HI) begin
          phase_next = PH_SAW_HI;
          pos_next   = POS_ONE;
        end else begin
          if (phase == PH_SAW_MK) begin
            pcmd.discard       = 1'b1;
            pcmd.clear_partial = 1'b1;
          end
          if (!is_digit) begin
            pcmd.discard       = 1'b1;
            pcmd.clear_partial = 1'b1;
            pcmd.code          = pfdq_pkg::ST_BAD_DIGIT;
            phase_next         = PH_HUNT;
            pos_next           = '0;
          end else if (dig_inc >= POS_DIGS) begin
            pcmd.clear_partial = 1'b1;
            phase_next         = (POS_PAD != '0) ? PH_PAD : PH_WORD;
            pos_next           = POS_PAD;
          end else begin
            phase_next = PH_DIGITS;
            pos_next   = dig_inc;
          end
        end
      end
      PH_PAD: begin
        pos_next = pad_dec;
        if (pad_dec == '0) begin
          phase_next         = PH_WORD;
          pcmd.clear_partial = 1'b1;
        end
      end
      PH_WORD: begin
        if (pos == POS_ONE && flags.partial_is_hi && rx_byte == pfdq_pkg::MARK_LO) begin
          phase_next         = PH_SAW_MK;
          pos_next           = POS_ONE;
          pcmd.clear_partial = 1'b1;
        end else if (pos < POS_THREE) begin
          pcmd.shift = 1'b1;
          pos_next   = pos + POS_ONE;
        end else if (flags.store_full) begin
          pcmd.discard       = 1'b1;
          pcmd.clear_partial = 1'b1;
          pcmd.code          = pfdq_pkg::ST_FULL;
          phase_next         = PH_HUNT;
          pos_next           = '0;
        end else begin
          pcmd.write_entry = 1'b1;
          pos_next         = '0;
        end
      end
      default: begin
        phase_next         = PH_HUNT;
        pos_next           = '0;
        pcmd.clear_partial = 1'b1;
      end
    endcase
  end

  always_comb begin
    seq_next = seq;
    cmd      = '0;
    cmd.code = pcmd.code;
    unique case (seq)
      SEQ_IDLE: begin
        if (accept && !req_type) begin
          cmd          = pcmd;
          cmd.res_load = 1'b1;
          seq_next     = SEQ_HOLD;
        end else if (accept) begin
          seq_next = SEQ_TICK;
        end
      end
      SEQ_TICK: begin
        cmd.tick = 1'b1;
        seq_next = SEQ_HOLD;
      end
      SEQ_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          seq_next     = SEQ_IDLE;
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SEQ_IDLE;
      phase     <= PH_HUNT;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      seq <= seq_next;
      if (accept && !req_type) begin
        phase <= phase_next;
        pos   <= pos_next;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/pfdq_dp.sv
// ----------------------------------------------------------------------------
// pfdq_dp
// word assembly, entry store, encounter queue, result and output registers
// ----------------------------------------------------------------------------
module pfdq_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  pfdq_pkg::cmd_t    cmd,
  output pfdq_pkg::flags_t  flags,
  output logic [2:0]        status,
  output logic [15:0]       azimuth_centi,
  output logic [15:0]       elevation_centi,
  output logic              encounter_done
);

  localparam logic [pfdq_pkg::ENTRY_PTR_W-1:0] ENTRY_LAST =
    pfdq_pkg::ENTRY_PTR_W'(pfdq_pkg::ENTRY_DEPTH - 1);
  localparam logic [pfdq_pkg::ENC_PTR_W-1:0] ENC_LAST =
    pfdq_pkg::ENC_PTR_W'(pfdq_pkg::ENCOUNTER_DEPTH - 1);

  logic [31:0]                      entry_mem [pfdq_pkg::ENTRY_DEPTH];
  logic [pfdq_pkg::USED_W-1:0]      enc_len   [pfdq_pkg::ENCOUNTER_DEPTH];
  logic [31:0]                      rd_data;

  logic [23:0]                      partial;
  logic [pfdq_pkg::ENTRY_PTR_W-1:0] rd_ptr, commit_ptr, wr_ptr;
  logic [pfdq_pkg::USED_W-1:0]      used, pending, head_rem;
  logic [pfdq_pkg::ENC_PTR_W-1:0]   head, tail;
  logic [pfdq_pkg::QUEUED_W-1:0]    queued;

  logic [pfdq_pkg::ENTRY_PTR_W-1:0] wr_ptr_next, rd_ptr_next;
  logic [pfdq_pkg::ENC_PTR_W-1:0]   head_next, tail_next;
  logic                             tick_has, pop, retire;
  logic [pfdq_pkg::USED_W-1:0]      rem_after;
  logic [pfdq_pkg::QUEUED_W-1:0]    queued_after;

  pfdq_pkg::status_t                res_status, out_status;
  logic [15:0]                      res_az, res_el;
  logic                             res_done;

  assign wr_ptr_next  = (wr_ptr == ENTRY_LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next  = (rd_ptr == ENTRY_LAST) ? '0 : rd_ptr + 1'b1;
  assign head_next    = (head == ENC_LAST) ? '0 : head + 1'b1;
  assign tail_next    = (tail == ENC_LAST) ? '0 : tail + 1'b1;
  assign tick_has     = (queued != '0);
  assign pop          = tick_has && (head_rem != '0);
  assign rem_after    = pop ? head_rem - 1'b1 : head_rem;
  assign retire       = tick_has && (rem_after == '0);
  assign queued_after = queued - 1'b1;

  assign flags.partial_is_hi = (partial == {16'h0000, pfdq_pkg::MARK_HI});
  assign flags.store_full    = (used >= pfdq_pkg::USED_W'(pfdq_pkg::ENTRY_DEPTH));
  assign flags.enc_full      = (queued >= pfdq_pkg::QUEUED_W'(pfdq_pkg::ENCOUNTER_DEPTH));

  // entry store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.write_entry) begin
      entry_mem[wr_ptr] <= {partial, rx_byte};
    end
    rd_data <= entry_mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      enc_len[tail] <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial    <= '0;
      rd_ptr     <= '0;
      commit_ptr <= '0;
      wr_ptr     <= '0;
      used       <= '0;
      pending    <= '0;
      head_rem   <= '0;
      head       <= '0;
      tail       <= '0;
      queued     <= '0;
    end else begin
      if (cmd.shift) begin
        partial <= {partial[15:0], rx_byte};
      end else if (cmd.clear_partial || cmd.write_entry) begin
        partial <= '0;
      end
      if (cmd.write_entry) begin
        wr_ptr  <= wr_ptr_next;
        used    <= used + 1'b1;
        pending <= pending + 1'b1;
      end else if (cmd.discard) begin
        used    <= used - pending;
        wr_ptr  <= commit_ptr;
        pending <= '0;
      end else if (cmd.commit) begin
        tail       <= tail_next;
        queued     <= queued + 1'b1;
        commit_ptr <= wr_ptr;
        pending    <= '0;
        if (queued == '0) begin
          head_rem <= pending;
        end
      end else if (cmd.tick) begin
        if (pop) begin
          rd_ptr <= rd_ptr_next;
          used   <= used - 1'b1;
        end
        if (retire) begin
          head   <= head_next;
          queued <= queued_after;
        end
        if (retire && queued_after != '0) begin
          head_rem <= enc_len[head_next];
        end else begin
          head_rem <= rem_after;
        end
      end
    end
  end

  // result staging and output register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.code;
      res_az     <= '0;
      res_el     <= '0;
      res_done   <= 1'b0;
    end else if (cmd.tick) begin
      res_status <= pop ? pfdq_pkg::ST_EXEC : pfdq_pkg::ST_NONE;
      res_az     <= pop ? rd_data[31:16] : 16'h0000;
      res_el     <= pop ? rd_data[15:0] : 16'h0000;
      res_done   <= retire;
    end
    if (cmd.out_load) begin
      out_status      <= res_status;
      azimuth_centi   <= res_az;
      elevation_centi <= res_el;
      encounter_done  <= res_done;
    end
  end

  assign status = out_status;

endmodule

// File: sv/pointing_frame_deframer_queue.sv
// ----------------------------------------------------------------------------
// pointing_frame_deframer_queue
// serial pointing frame deframer with a queue of encounters popped by ticks
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A byte beat goes from accept to a hold
// state, left once the output is free; an execute tick first passes a tick
// state that uses the registered entry store read. A finished result sits in
// a staging register, then moves to the output register once that is free,
// so a new beat can be taken while the previous result waits downstream.
// The entry store needs no clearing pass after reset.
module pointing_frame_deframer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] azimuth_centi,
  output logic [15:0] elevation_centi,
  output logic        encounter_done
);

  pfdq_pkg::cmd_t   cmd;
  pfdq_pkg::flags_t flags;

  pfdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  pfdq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .rx_byte         (rx_byte),
    .cmd             (cmd),
    .flags           (flags),
    .status          (status),
    .azimuth_centi   (azimuth_centi),
    .elevation_centi (elevation_centi),
    .encounter_done  (encounter_done)
  );

endmodule

// File: bench/pfdq_tracker.sv
// ----------------------------------------------------------------------------
// pfdq_tracker
// watches both channels of the pointing frame deframer queue, keeps its own
// copy of the parser, entry store and encounter queue, predicts the result of
// every accepted input beat and compares each output beat field by field
// ----------------------------------------------------------------------------
module pfdq_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [15:0] azimuth_centi,
  input  logic [15:0] elevation_centi,
  input  logic        encounter_done,
  output int          error_count,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    HUNT, SAW_HI, SAW_MARK, SAW_MARK_HI, DIGITS, PAD, WORD
  } parse_phase_t;

  typedef struct packed {
    pfdq_pkg::status_t code;
    logic [15:0]       azimuth;
    logic [15:0]       elevation;
    logic              done;
  } pointing_result_t;

  parse_phase_t     phase;
  int unsigned      pos;
  logic [23:0]      partial;
  logic [31:0]      entries [pfdq_pkg::ENTRY_DEPTH];
  int unsigned      rd_ptr, commit_ptr, wr_ptr, used, open_len;
  int unsigned      enc_len [pfdq_pkg::ENCOUNTER_DEPTH];
  int unsigned      enc_head, enc_tail, enc_count, head_left;
  pointing_result_t expected_results [$];

  function automatic int unsigned ring_next(int unsigned p, int unsigned depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  function automatic void discard_open_frame();
    used -= open_len;
    wr_ptr = commit_ptr;
    open_len = 0;
  endfunction

  function automatic pfdq_pkg::status_t drop_frame(pfdq_pkg::status_t code);
    discard_open_frame();
    phase = HUNT;
    pos = 0;
    partial = '0;
    return code;
  endfunction

  function automatic pfdq_pkg::status_t take_digit(logic [7:0] b);
    if (b < pfdq_pkg::CHAR_ZERO || b > pfdq_pkg::CHAR_NINE)
      return drop_frame(pfdq_pkg::ST_BAD_DIGIT);
    pos++;
    if (pos >= pfdq_pkg::TIME_DIGITS) begin
      phase = (pfdq_pkg::PAD_LEN != 0) ? PAD : WORD;
      pos = pfdq_pkg::PAD_LEN;
      partial = '0;
    end
    return pfdq_pkg::ST_TAKEN;
  endfunction

  function automatic pfdq_pkg::status_t parse_byte(logic [7:0] b);
    logic opened;
    opened = (pos != 0);
    case (phase)
      HUNT: begin
        if (b == pfdq_pkg::MARK_HI) begin
          phase = SAW_HI;
          pos = 0;
        end
        return pfdq_pkg::ST_TAKEN;
      end
      SAW_HI: begin
        if (b == pfdq_pkg::MARK_LO) begin
          phase = SAW_MARK;
          return pfdq_pkg::ST_TAKEN;
        end
        if (opened) return drop_frame(pfdq_pkg::ST_BAD_DIGIT);
        if (b != pfdq_pkg::MARK_HI) phase = HUNT;
        return pfdq_pkg::ST_TAKEN;
      end
      SAW_MARK: begin
        if (b == pfdq_pkg::MARK_HI) begin
          phase = SAW_MARK_HI;
          return pfdq_pkg::ST_TAKEN;
        end
        // fresh marker: open frame is thrown away, this byte is the first digit
        discard_open_frame();
        phase = DIGITS;
        pos = 0;
        partial = '0;
        return take_digit(b);
      end
      SAW_MARK_HI: begin
        if (b != pfdq_pkg::MARK_LO) return drop_frame(pfdq_pkg::ST_BAD_DIGIT);
        if (!opened) begin
          phase = HUNT;
          pos = 0;
          return pfdq_pkg::ST_TAKEN;
        end
        if (enc_count >= pfdq_pkg::ENCOUNTER_DEPTH) return drop_frame(pfdq_pkg::ST_FULL);
        enc_len[enc_tail] = open_len;
        enc_tail = ring_next(enc_tail, pfdq_pkg::ENCOUNTER_DEPTH);
        if (enc_count == 0) head_left = open_len;
        enc_count++;
        commit_ptr = wr_ptr;
        open_len = 0;
        phase = HUNT;
        pos = 0;
        partial = '0;
        return pfdq_pkg::ST_COMMIT;
      end
      DIGITS: begin
        if (pos == 0 && b == pfdq_pkg::MARK_HI) begin
          phase = SAW_HI;
          pos = 1;
          return pfdq_pkg::ST_TAKEN;
        end
        return take_digit(b);
      end
      PAD: begin
        if (pos > 0) pos--;
        if (pos == 0) begin
          phase = WORD;
          partial = '0;
        end
        return pfdq_pkg::ST_TAKEN;
      end
      WORD: begin
        if (pos == 1 && partial == pfdq_pkg::MARK_HI && b == pfdq_pkg::MARK_LO) begin
          phase = SAW_MARK;
          pos = 1;
          partial = '0;
          return pfdq_pkg::ST_TAKEN;
        end
        if (pos < 3) begin
          partial = {partial[15:0], b};
          pos++;
          return pfdq_pkg::ST_TAKEN;
        end
        if (used >= pfdq_pkg::ENTRY_DEPTH) return drop_frame(pfdq_pkg::ST_FULL);
        entries[wr_ptr] = {partial, b};
        wr_ptr = ring_next(wr_ptr, pfdq_pkg::ENTRY_DEPTH);
        used++;
        open_len++;
        pos = 0;
        partial = '0;
        return pfdq_pkg::ST_TAKEN;
      end
      default: begin
        phase = HUNT;
        pos = 0;
        partial = '0;
        return pfdq_pkg::ST_TAKEN;
      end
    endcase
  endfunction

  function automatic pointing_result_t predict_pointing(logic is_tick, logic [7:0] b);
    pointing_result_t r;
    logic [31:0]      word;
    r.code = pfdq_pkg::ST_NONE;
    r.azimuth = '0;
    r.elevation = '0;
    r.done = 1'b0;
    if (!is_tick) begin
      r.code = parse_byte(b);
    end else if (enc_count > 0) begin
      if (head_left > 0) begin
        word = entries[rd_ptr];
        r.azimuth = word[31:16];
        r.elevation = word[15:0];
        r.code = pfdq_pkg::ST_EXEC;
        rd_ptr = ring_next(rd_ptr, pfdq_pkg::ENTRY_DEPTH);
        used--;
        head_left--;
      end
      if (head_left == 0) begin
        enc_head = ring_next(enc_head, pfdq_pkg::ENCOUNTER_DEPTH);
        enc_count--;
        r.done = 1'b1;
        if (enc_count > 0) head_left = enc_len[enc_head];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pointing_result_t want;
    if (rst) begin
      phase = HUNT;
      pos = 0;
      partial = '0;
      rd_ptr = 0;
      commit_ptr = 0;
      wr_ptr = 0;
      used = 0;
      open_len = 0;
      enc_head = 0;
      enc_tail = 0;
      enc_count = 0;
      head_left = 0;
      error_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d", status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.code) begin
            $error("status: expected %0d, got %0d", want.code, status);
            error_count++;
          end
          if (azimuth_centi !== want.azimuth) begin
            $error("azimuth_centi: expected %0d, got %0d", want.azimuth, azimuth_centi);
            error_count++;
          end
          if (elevation_centi !== want.elevation) begin
            $error("elevation_centi: expected %0d, got %0d", want.elevation,
                   elevation_centi);
            error_count++;
          end
          if (encounter_done !== want.done) begin
            $error("encounter_done: expected %0d, got %0d", want.done, encounter_done);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_pointing(req_type, rx_byte));
    end
    results_due <= expected_results.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives serial bytes and execute ticks into the pointing frame deframer
// queue: a few directed beats, then mostly well-formed frames with random
// time digits and angles, mixed with broken frames, noise, tick bursts and
// encounter queue overflow; both sides idle and stall at random
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   BEATS_WANTED   = 1950;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   DRAIN_CYCLES   = 20;
  localparam logic REQ_BYTE       = 1'b0;
  localparam logic REQ_TICK       = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] azimuth_centi;
  logic [15:0] elevation_centi;
  logic        encounter_done;

  int          error_count;
  int          results_due;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  bit          in_calm = 1'b1;
  bit          out_calm = 1'b0;
  int unsigned out_hold = 0;
  int unsigned tick_mix = 0;

  pointing_frame_deframer_queue DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .azimuth_centi   (azimuth_centi),
    .elevation_centi (elevation_centi),
    .encounter_done  (encounter_done)
  );

  pfdq_tracker tracker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .azimuth_centi   (azimuth_centi),
    .elevation_centi (elevation_centi),
    .encounter_done  (encounter_done),
    .error_count     (error_count),
    .results_due     (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // downstream stalls
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) out_calm <= !out_calm;
    if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 99) < 25)
        out_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pointing_frame_deframer_queue: mismatch");
      $finish;
    end
  end

  task automatic send_beat(input logic kind, input logic [7:0] data);
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    gap = (in_calm || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    rx_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // a tick may slip in before any byte
  task automatic send_byte(input logic [7:0] data);
    if ($urandom_range(0, 99) < tick_mix) send_beat(REQ_TICK, 8'($urandom));
    send_beat(REQ_BYTE, data);
  endtask

  task automatic send_close();
    send_byte(pfdq_pkg::MARK_HI);
    send_byte(pfdq_pkg::MARK_LO);
    send_byte(pfdq_pkg::MARK_HI);
    send_byte(pfdq_pkg::MARK_LO);
  endtask

  function automatic logic [31:0] pick_word(input bit plain);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (!plain && r == 2) return {pfdq_pkg::MARK_HI, pfdq_pkg::MARK_LO, 16'($urandom)};
    if (r == 3) return {pfdq_pkg::MARK_HI, 24'($urandom)};
    return $urandom;
  endfunction

  task automatic send_frame(input int words, input bit close, input int bad_at,
                            input bit plain);
    logic [31:0] word;
    logic [7:0]  bad;
    send_byte(pfdq_pkg::MARK_HI);
    send_byte(pfdq_pkg::MARK_LO);
    for (int i = 0; i < pfdq_pkg::TIME_DIGITS; i++) begin
      if (i == bad_at) begin
        bad = ($urandom_range(0, 3) == 0) ? pfdq_pkg::MARK_HI : 8'($urandom);
        if (bad >= pfdq_pkg::CHAR_ZERO && bad <= pfdq_pkg::CHAR_NINE)
          bad = ($urandom_range(0, 1) != 0) ? pfdq_pkg::CHAR_ZERO - 8'd1
                                            : pfdq_pkg::CHAR_NINE + 8'd1;
        send_byte(bad);
      end else begin
        send_byte(pfdq_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    for (int i = 0; i < pfdq_pkg::PAD_LEN; i++) send_byte(8'($urandom));
    for (int w = 0; w < words; w++) begin
      word = pick_word(plain);
      for (int k = 3; k >= 0; k--) send_byte(word[8*k +: 8]);
    end
    if (close) send_close();
  endtask

  initial begin
    int unsigned pick;
    int unsigned words;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // close with no frame open, tick on an empty queue, empty encounter
    send_close();
    send_beat(REQ_TICK, 8'hFF);
    send_frame(0, 1'b1, -1, 1'b1);
    send_beat(REQ_TICK, 8'h00);

    tick_mix = 4;
    while (beats_sent < BEATS_WANTED) begin
      in_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      words = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
      if (pick < 40) begin
        send_frame(words, 1'b1, -1, 1'b0);
      end else if (pick < 50) begin
        send_frame(words, 1'b1, $urandom_range(0, pfdq_pkg::TIME_DIGITS - 1), 1'b0);
      end else if (pick < 56) begin
        send_frame($urandom_range(0, 3), 1'b0, -1, 1'b0);
        send_frame(words, 1'b1, -1, 1'b0);
      end else if (pick < 60) begin
        send_frame($urandom_range(0, 3), 1'b0, -1, 1'b0);
        send_byte(pfdq_pkg::MARK_HI);
        send_byte(pfdq_pkg::MARK_LO);
        send_byte(pfdq_pkg::MARK_HI);
        send_byte(pfdq_pkg::MARK_LO ^ 8'($urandom_range(1, 255)));
      end else if (pick < 63) begin
        send_frame(words, 1'b1, -1, 1'b0);
        send_close();
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 12)) send_beat(REQ_TICK, 8'($urandom));
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 8)) send_beat(REQ_BYTE, 8'($urandom));
      end else begin
        repeat (pfdq_pkg::ENCOUNTER_DEPTH + 1) send_frame(0, 1'b1, -1, 1'b1);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_due == 0) $display("pointing_frame_deframer_queue: match");
    else $display("pointing_frame_deframer_queue: mismatch");
    $finish;
  end

endmodule
